// ===== rtl/core/csr_rf_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and address decode for the csr register file
package csr_rf_pkg;

    localparam int BANK_DEPTH = 45;
    localparam int SLOT_W     = $clog2(BANK_DEPTH);
    localparam int XLEN       = 64;
    localparam int ADDR_W     = 12;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [XLEN-1:0]   t_xword;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_op;
    typedef logic [2:0]        t_kind;

    typedef struct packed {
        logic  hit;
        t_slot slot;
    } t_slot_hit;

    // request types
    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_SET   = 2'd2;
    localparam t_op OP_CLEAR = 2'd3;

    // address classes
    localparam t_kind KIND_STORED    = 3'd0;
    localparam t_kind KIND_ZERO      = 3'd1;
    localparam t_kind KIND_COUNTEREN = 3'd2;
    localparam t_kind KIND_TIME      = 3'd3;
    localparam t_kind KIND_TICK      = 3'd4;
    localparam t_kind KIND_ILLEGAL   = 3'd5;
    localparam t_kind KIND_UNKNOWN   = 3'd6;

    localparam t_xword COUNTEREN_VALUE = t_xword'(7);

    // bank slot of misa (0x301)
    localparam t_slot MISA_SLOT = t_slot'(13);

    localparam t_addr BANK_ADDR [BANK_DEPTH] = '{
        12'h003,
        12'h100, 12'h102, 12'h103, 12'h104, 12'h105,
        12'h140, 12'h141, 12'h142, 12'h143, 12'h144,
        12'h180,
        12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305,
        12'h340, 12'h341, 12'h342, 12'h343, 12'h344,
        12'h3A0, 12'h3A2,
        12'h3B0, 12'h3B1, 12'h3B2, 12'h3B3, 12'h3B4, 12'h3B5, 12'h3B6, 12'h3B7,
        12'h3B8, 12'h3B9, 12'h3BA, 12'h3BB, 12'h3BC, 12'h3BD, 12'h3BE, 12'h3BF,
        12'hF11, 12'hF12, 12'hF13, 12'hF14
    };

    // parallel compare against every stored address
    function automatic t_slot_hit lookup_slot(input t_addr addr);
        t_slot_hit res;
        res = '0;
        for (int i = 0; i < BANK_DEPTH; i++) begin
            if (BANK_ADDR[i] == addr) begin
                res.hit  = 1'b1;
                res.slot = t_slot'(i);
            end
        end
        return res;
    endfunction

    function automatic t_kind decode_kind(input t_addr addr, input logic hit);
        t_kind k;
        if (hit) begin
            k = KIND_STORED;
        end else if (addr == 12'h000) begin
            k = KIND_ZERO;
        end else if (addr == 12'h106 || addr == 12'h306) begin
            k = KIND_COUNTEREN;
        end else if (addr == 12'hC01) begin
            k = KIND_TIME;
        end else if (addr == 12'hC00 || addr == 12'hC02) begin
            k = KIND_TICK;
        end else if ((addr >= 12'h3C0 && addr <= 12'h3EF) ||
                     (addr >= 12'hB03 && addr <= 12'hB1F)) begin
            k = KIND_ILLEGAL;
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/csr_rf_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module csr_rf_ram #(
    parameter int P_WIDTH = 64,
    parameter int P_DEPTH = 45
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/csr_register_file.sv =====
`timescale 1ns / 1ps
// top level of the csr register file: decode, bank access and result register
//
// Control and status register file for one RISC-V hart. Each request beat
// carries a 12-bit csr address and an operation (read, write, set bits, clear
// bits) and returns exactly one result beat holding the register's old value.
// 45 registers are stored in a small ram; the counter-enable registers read as
// 7, time returns the rtc value sent with the request, and cycle and instret
// return the tick value sent with it. pmpaddr16..63 and mhpmcounter3..31 set
// the illegal flag, other unrecognized nonzero addresses set the unknown flag;
// either flag forces zero data and suppresses the write. Address zero reads
// zero. The block takes one request per cycle while the result side keeps
// draining. Decode and the ram read address settle in the accepting cycle;
// the stage 1 register then holds the request and its ram read data, and the
// read-modify-write goes into the result register once that is free or being
// drained. A request that follows a write to the same register sees the new
// value through a bypass around the ram. The config beat sets the misa reset
// value and reloads misa at once; it is meant to arrive while no request is in
// flight. After reset every stored register reads as zero (misa too, until a
// config beat) through per-entry valid bits, so no clearing pass is needed.
module csr_register_file (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: misa reset value
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [63:0]               i_cfg_data,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_req_type,
    input  logic [11:0]               i_csr_addr,
    input  logic [63:0]               i_write_data,
    input  logic [63:0]               i_rtc_time,
    input  logic [63:0]               i_tick_count,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [63:0]               o_read_data,
    output logic                      o_illegal_access,
    output logic                      o_unknown_address
);

    import csr_rf_pkg::*;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    t_slot_hit w_in_hit;
    t_kind     w_in_kind;
    t_xword    w_in_fixed;
    logic      w_in_beat;
    logic      w_cfg_beat;

    assign w_in_hit  = lookup_slot(i_csr_addr);
    assign w_in_kind = decode_kind(i_csr_addr, w_in_hit.hit);

    // value for addresses that do not live in the bank
    always_comb begin
        case (w_in_kind)
            KIND_COUNTEREN: w_in_fixed = COUNTEREN_VALUE;
            KIND_TIME:      w_in_fixed = i_rtc_time;
            KIND_TICK:      w_in_fixed = i_tick_count;
            default:        w_in_fixed = '0;
        endcase
    end

    assign w_in_beat  = i_valid && o_ready;
    assign w_cfg_beat = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // stage 1: decoded request, ram read data arrives here
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    t_op              r_op;
    t_kind            r_kind;
    t_slot            r_slot;
    t_xword           r_data;
    t_xword           r_fixed;
    logic             r_fwd_hit;
    t_xword           r_fwd_data;

    logic [BANK_DEPTH-1:0] r_valid;     // entry written since reset (misa: since the last config beat)
    t_xword                r_misa_reset;

    // result register
    logic   r_out_valid;
    t_xword r_out_data;
    logic   r_out_illegal;
    logic   r_out_unknown;

    t_xword w_ram_rdata;
    t_xword w_old_ram;
    t_xword w_old_store;
    t_xword w_old;
    t_xword w_new;
    logic   w_s1_adv;
    logic   w_we;
    logic   w_fwd;

    // stage 1 moves on when the result register is free or being drained
    assign w_s1_adv = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || w_s1_adv;

    // bypass: ram read issued in the same cycle as the write it depends on
    assign w_old_ram = r_fwd_hit ? r_fwd_data : w_ram_rdata;

    // never-written entries read as their reset value
    always_comb begin
        if (r_valid[r_slot]) begin
            w_old_store = w_old_ram;
        end else if (r_slot == MISA_SLOT) begin
            w_old_store = r_misa_reset;
        end else begin
            w_old_store = '0;
        end
    end

    assign w_old = (r_kind == KIND_STORED) ? w_old_store : r_fixed;

    always_comb begin
        case (r_op)
            OP_WRITE: w_new = r_data;
            OP_SET:   w_new = w_old | r_data;
            OP_CLEAR: w_new = w_old & ~r_data;
            default:  w_new = w_old;
        endcase
    end

    assign w_we  = w_s1_adv && (r_kind == KIND_STORED) && (r_op != OP_READ);
    assign w_fwd = w_we && (r_slot == w_in_hit.slot) && (w_in_kind == KIND_STORED);

    csr_rf_ram #(
        .P_WIDTH (XLEN),
        .P_DEPTH (BANK_DEPTH)
    ) u_bank (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_new),
        .i_re    (w_in_beat),
        .i_raddr (w_in_hit.slot),
        .o_rdata (w_ram_rdata)
    );

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_op       <= i_req_type;
            r_kind     <= w_in_kind;
            r_slot     <= w_in_hit.slot;
            r_data     <= i_write_data;
            r_fixed    <= w_in_fixed;
            r_fwd_hit  <= w_fwd;
            r_fwd_data <= w_new;
        end
    end

    // control state, valid bits and the misa reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_valid      <= '0;
            r_misa_reset <= '0;
        end else begin
            if (w_in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_we) begin
                r_valid[r_slot] <= 1'b1;
            end
            // config reloads misa: drop the stored copy, the reset value shows
            if (w_cfg_beat) begin
                r_misa_reset       <= i_cfg_data;
                r_valid[MISA_SLOT] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data    <= w_old;
            r_out_illegal <= (r_kind == KIND_ILLEGAL);
            r_out_unknown <= (r_kind == KIND_UNKNOWN);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_read_data       = r_out_data;
    assign o_illegal_access  = r_out_illegal;
    assign o_unknown_address = r_out_unknown;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_write_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_s1_adv && r_kind == KIND_STORED))
        else $error("bank write without a stored request leaving stage 1");

    a_fault_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_illegal_access || o_unknown_address)) |->
            (o_read_data == '0 && !(o_illegal_access && o_unknown_address)))
        else $error("faulting result carries data or both flags");

    a_result_side_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_ready) |-> o_ready)
        else $error("request side stalled while result side can drain");

    a_cfg_reloads_misa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_beat |=> (!r_valid[MISA_SLOT] && r_misa_reset == $past(i_cfg_data)))
        else $error("config beat did not reload misa");

endmodule

// ===== tb/sv/csr_register_file_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the csr register file: random and directed csr accesses
module csr_register_file_tb;
    import csr_rf_pkg::*;

    localparam int     CYCLE_LIMIT      = 1_000_000;
    localparam int     LONG_HOLD_CYCLES = 300;
    localparam int     SETTLE_CYCLES    = 8;
    localparam int     ITEMS_PER_PHASE  = 320;
    localparam t_addr  MISA_CSR         = 12'h301;
    localparam t_xword CTREN_READ_VALUE = 64'd7;
    localparam t_xword ALL_ONES         = '1;

    typedef enum logic [2:0] {
        ADDR_BANKED, ADDR_ZERO, ADDR_CTREN, ADDR_RTC, ADDR_TICK, ADDR_ILLEGAL, ADDR_UNKNOWN
    } t_addr_class;

    typedef struct packed {
        t_op    op;
        t_addr  addr;
        t_xword wdata;
        t_xword rtc;
        t_xword tick;
    } t_csr_req;

    typedef struct packed {
        t_xword data;
        logic   illegal;
        logic   unknown;
    } t_csr_result;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_cfg_valid       = 1'b0;
    logic [63:0] i_cfg_data        = '0;
    logic        i_valid           = 1'b0;
    logic [1:0]  i_req_type        = '0;
    logic [11:0] i_csr_addr        = '0;
    logic [63:0] i_write_data      = '0;
    logic [63:0] i_rtc_time        = '0;
    logic [63:0] i_tick_count      = '0;
    logic        i_ready           = 1'b0;
    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_read_data;
    logic        o_illegal_access;
    logic        o_unknown_address;

    // predictor state: one 64-bit shadow per address, only stored ones ever change
    t_xword      csr_mirror [4096];
    t_addr       banked_list [$];
    t_csr_req    csr_req_q [$];
    t_csr_result old_value_q [$];

    int fail_count        = 0;
    int cycle_count       = 0;
    int req_beats         = 0;
    int req_beats_seen    = 0;
    int req_gap_left      = 0;
    int rsp_stall_left    = 0;
    int long_holds_wanted = 0;
    int long_holds_done   = 0;
    bit req_gaps_on       = 1'b1;
    bit rsp_gaps_on       = 1'b1;

    csr_register_file DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_csr_addr        (i_csr_addr),
        .i_write_data      (i_write_data),
        .i_rtc_time        (i_rtc_time),
        .i_tick_count      (i_tick_count),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_read_data       (o_read_data),
        .o_illegal_access  (o_illegal_access),
        .o_unknown_address (o_unknown_address)
    );

    initial begin : clk_gen
        forever #5 i_clk = ~i_clk;
    end

    // address map of the hart, written as ranges
    function automatic t_addr_class classify_addr(input t_addr a);
        if (a == 12'h003 || a == 12'h100 || (a >= 12'h102 && a <= 12'h105) ||
            (a >= 12'h140 && a <= 12'h144) || a == 12'h180 ||
            (a >= 12'h300 && a <= 12'h305) || (a >= 12'h340 && a <= 12'h344) ||
            a == 12'h3A0 || a == 12'h3A2 || (a >= 12'h3B0 && a <= 12'h3BF) ||
            (a >= 12'hF11 && a <= 12'hF14)) begin
            return ADDR_BANKED;
        end
        if (a == 12'h000) return ADDR_ZERO;
        if (a == 12'h106 || a == 12'h306) return ADDR_CTREN;
        if (a == 12'hC01) return ADDR_RTC;
        if (a == 12'hC00 || a == 12'hC02) return ADDR_TICK;
        if ((a >= 12'h3C0 && a <= 12'h3EF) || (a >= 12'hB03 && a <= 12'hB1F)) return ADDR_ILLEGAL;
        return ADDR_UNKNOWN;
    endfunction

    // old value and flags of one access; updates the shadow for stored registers
    function automatic t_csr_result csr_access_predict(input t_op op, input t_addr a,
                                                       input t_xword wdata, input t_xword rtc,
                                                       input t_xword tick);
        t_csr_result r;
        t_xword      old;
        r = '0;
        case (classify_addr(a))
            ADDR_BANKED: begin
                old = csr_mirror[a];
                case (op)
                    OP_WRITE: csr_mirror[a] = wdata;
                    OP_SET:   csr_mirror[a] = old | wdata;
                    OP_CLEAR: csr_mirror[a] = old & ~wdata;
                    default:  ;
                endcase
                r.data = old;
            end
            ADDR_CTREN:   r.data = CTREN_READ_VALUE;
            ADDR_RTC:     r.data = rtc;
            ADDR_TICK:    r.data = tick;
            ADDR_ILLEGAL: r.illegal = 1'b1;
            ADDR_UNKNOWN: r.unknown = 1'b1;
            default:      r.data = '0;
        endcase
        return r;
    endfunction

    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_xword rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return ALL_ONES;
        if (r == 2) return t_xword'(1) << $urandom_range(0, 63);
        return {$urandom, $urandom};
    endfunction

    function automatic t_addr pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return banked_list[$urandom_range(0, banked_list.size() - 1)];
        if (r < 50) return 12'h000;
        if (r < 55) return $urandom_range(0, 1) ? 12'h106 : 12'h306;
        if (r < 60) return 12'hC01;
        if (r < 65) return $urandom_range(0, 1) ? 12'hC00 : 12'hC02;
        if (r < 72) begin
            if ($urandom_range(0, 1)) return t_addr'($urandom_range(12'h3C0, 12'h3EF));
            return t_addr'($urandom_range(12'hB03, 12'hB1F));
        end
        return t_addr'($urandom_range(0, 4095));
    endfunction

    task automatic push_req(input t_op op, input t_addr a, input t_xword wdata,
                            input t_xword rtc, input t_xword tick);
        t_csr_req req;
        req = '{op: op, addr: a, wdata: wdata, rtc: rtc, tick: tick};
        csr_req_q.push_back(req);
    endtask

    // half of the draws queue a run on one stored register: a write, two random operations, a read
    task automatic queue_random_traffic(input int n);
        int    cnt;
        int    k;
        t_addr a;
        t_op   op;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 1)) begin
                a = banked_list[$urandom_range(0, banked_list.size() - 1)];
                for (k = 0; k < 4; k++) begin
                    if (k == 0) op = OP_WRITE;
                    else if (k == 3) op = OP_READ;
                    else op = t_op'($urandom_range(0, 3));
                    push_req(op, a, rand_word(), rand_word(), rand_word());
                end
                cnt += 4;
            end else begin
                push_req(t_op'($urandom_range(0, 3)), pick_addr(), rand_word(), rand_word(),
                         rand_word());
                cnt++;
            end
        end
    endtask

    task automatic queue_directed();
        t_xword rnd;
        rnd = {$urandom, $urandom};
        // misa at its reset value, then read-modify-write on mscratch
        push_req(OP_READ,  MISA_CSR, ALL_ONES, rnd, rnd);
        push_req(OP_WRITE, 12'h340, ALL_ONES, rnd, rnd);
        push_req(OP_SET,   12'h340, '0, rnd, rnd);
        push_req(OP_CLEAR, 12'h340, 64'h5555_5555_5555_5555, rnd, rnd);
        push_req(OP_READ,  12'h340, '0, rnd, rnd);
        // lowest and highest stored addresses
        push_req(OP_WRITE, 12'h003, ALL_ONES, rnd, rnd);
        push_req(OP_WRITE, 12'hF14, 64'h8000_0000_0000_0000, rnd, rnd);
        push_req(OP_READ,  12'hF14, ALL_ONES, rnd, rnd);
        push_req(OP_CLEAR, 12'h003, ALL_ONES, rnd, rnd);
        push_req(OP_READ,  12'h003, '0, rnd, rnd);
        // address zero and counter enables drop writes
        push_req(OP_WRITE, 12'h000, ALL_ONES, rnd, rnd);
        push_req(OP_READ,  12'h000, '0, rnd, rnd);
        push_req(OP_WRITE, 12'h106, '0, rnd, rnd);
        push_req(OP_READ,  12'h306, ALL_ONES, rnd, rnd);
        // time, cycle and instret pass the supplied values through
        push_req(OP_READ,  12'hC01, '0, '0, ALL_ONES);
        push_req(OP_WRITE, 12'hC01, ALL_ONES, ALL_ONES, '0);
        push_req(OP_READ,  12'hC00, '0, '0, ALL_ONES);
        push_req(OP_SET,   12'hC02, ALL_ONES, ALL_ONES, '0);
        // edges of the illegal ranges
        push_req(OP_WRITE, 12'h3C0, ALL_ONES, rnd, rnd);
        push_req(OP_SET,   12'h3EF, ALL_ONES, rnd, rnd);
        push_req(OP_CLEAR, 12'hB03, ALL_ONES, rnd, rnd);
        push_req(OP_READ,  12'hB1F, '0, rnd, rnd);
        // just outside them and at the top of the space: unknown
        push_req(OP_WRITE, 12'h3F0, ALL_ONES, rnd, rnd);
        push_req(OP_READ,  12'hB02, '0, rnd, rnd);
        push_req(OP_SET,   12'hFFF, ALL_ONES, rnd, rnd);
        push_req(OP_READ,  12'hB20, '0, rnd, rnd);
    endtask

    task automatic write_misa_cfg(input t_xword value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        // the misa entry reloads together with its reset value
        csr_mirror[MISA_CSR] = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (csr_req_q.size() != 0 || i_valid || old_value_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // request side: one beat per accepted handshake, gaps drawn per item
    always @(negedge i_clk) begin : req_drive
        t_csr_req nxt;
        logic     waiting;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            waiting = i_valid && (req_beats == req_beats_seen);
            req_beats_seen = req_beats;
            if (!waiting) begin
                if (req_gap_left > 0) begin
                    req_gap_left--;
                    i_valid <= 1'b0;
                end else if (csr_req_q.size() != 0) begin
                    nxt = csr_req_q.pop_front();
                    i_valid      <= 1'b1;
                    i_req_type   <= nxt.op;
                    i_csr_addr   <= nxt.addr;
                    i_write_data <= nxt.wdata;
                    i_rtc_time   <= nxt.rtc;
                    i_tick_count <= nxt.tick;
                    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
                        req_gap_left = pick_gap_len();
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : req_capture
        if (i_rst_n && i_valid && o_ready) begin
            old_value_q.push_back(csr_access_predict(i_req_type, i_csr_addr, i_write_data,
                                                     i_rtc_time, i_tick_count));
            req_beats++;
        end
    end

    // result side: random stalls, plus a long hold-off when one is requested
    always @(negedge i_clk) begin : rsp_pace
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rsp_stall_left == 0) begin
                if (long_holds_done < long_holds_wanted) begin
                    long_holds_done++;
                    rsp_stall_left = LONG_HOLD_CYCLES;
                end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
                    rsp_stall_left = pick_gap_len();
                end
            end
            if (rsp_stall_left > 0) begin
                rsp_stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_csr_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (old_value_q.size() == 0) begin
                $error("result beat with no request outstanding");
                fail_count++;
            end else begin
                want = old_value_q.pop_front();
                if (o_read_data !== want.data) begin
                    $error("read_data: expected %h, got %h", want.data, o_read_data);
                    fail_count++;
                end
                if (o_illegal_access !== want.illegal) begin
                    $error("illegal_access: expected %b, got %b", want.illegal,
                           o_illegal_access);
                    fail_count++;
                end
                if (o_unknown_address !== want.unknown) begin
                    $error("unknown_address: expected %b, got %b", want.unknown,
                           o_unknown_address);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_xword misa_cfg [5];
        int     a;
        int     ph;
        misa_cfg[0] = ALL_ONES;
        misa_cfg[1] = '0;
        misa_cfg[2] = {$urandom, $urandom};
        misa_cfg[3] = 64'h8000_0000_0000_0000;
        misa_cfg[4] = {$urandom, $urandom};
        for (a = 0; a < 4096; a++) begin
            csr_mirror[a] = '0;
            if (classify_addr(t_addr'(a)) == ADDR_BANKED) banked_list.push_back(t_addr'(a));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // misa still at its reset value during the first pass
        queue_directed();
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        for (ph = 0; ph < 5; ph++) begin
            write_misa_cfg(misa_cfg[ph]);
            // phase 0 runs back to back, phase 1 fills the block behind a long stall
            req_gaps_on = (ph != 0) && (ph != 4);
            rsp_gaps_on = (ph != 0) && (ph != 3);
            if (ph == 1) long_holds_wanted++;
            queue_random_traffic(ITEMS_PER_PHASE);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
